>>> rtl/core/pae_pkg.sv
// Shared widths, register indexes and effect codes for the pixel alpha effect core.
`default_nettype none

package pae_pkg;

	// pixel channel and register widths
	localparam int ColW   = 8;
	localparam int StyleW = 12;
	localparam int CfgAW  = 3;
	localparam int CfgDW  = StyleW;

	// shared divider: 16-bit dividend, 8-bit divisor, quotient known to fit 8 bits
	localparam int DivNW   = 2 * ColW;
	localparam int DivDW   = ColW;
	localparam int DivQW   = ColW;
	localparam int DivStep = 2;

	// divide by three as multiply by 683 and shift by 11 (exact below 2048)
	localparam int         Rcp3W  = 11;
	localparam logic [Rcp3W-1:0] RCP3 = 11'd683;
	localparam int         Rcp3Sh = 11;

	localparam logic [ColW-1:0] COL_MAX  = 8'd255;
	localparam logic [ColW-1:0] COL_HALF = 8'd128;
	localparam logic [ColW-1:0] COL_MAG2 = 8'd192;
	localparam logic [ColW-1:0] ALPHA_HALF    = 8'd128;
	localparam logic [ColW-1:0] ALPHA_QUARTER = 8'd64;

	// configuration register indexes
	localparam logic [CfgAW-1:0] REG_STYLE = 3'd0;
	localparam logic [CfgAW-1:0] REG_ALPHA = 3'd1;
	localparam logic [CfgAW-1:0] REG_KEY_R = 3'd2;
	localparam logic [CfgAW-1:0] REG_KEY_G = 3'd3;
	localparam logic [CfgAW-1:0] REG_KEY_B = 3'd4;

	// base effect codes (style bits 5..0)
	localparam int EffW = 6;
	localparam logic [EffW-1:0] EFF_KEEP     = 6'd0;
	localparam logic [EffW-1:0] EFF_SET      = 6'd1;
	localparam logic [EffW-1:0] EFF_KEY_OPQ  = 6'd2;
	localparam logic [EffW-1:0] EFF_KEY_CLR  = 6'd3;
	localparam logic [EffW-1:0] EFF_BRIGHT   = 6'd4;
	localparam logic [EffW-1:0] EFF_LIGHT    = 6'd5;
	localparam logic [EffW-1:0] EFF_MIN      = 6'd6;
	localparam logic [EffW-1:0] EFF_MAX      = 6'd7;
	localparam logic [EffW-1:0] EFF_SAT      = 6'd8;
	localparam logic [EffW-1:0] EFF_RED      = 6'd9;
	localparam logic [EffW-1:0] EFF_GREEN    = 6'd10;
	localparam logic [EffW-1:0] EFF_BLUE     = 6'd11;
	localparam logic [EffW-1:0] EFF_GB       = 6'd12;
	localparam logic [EffW-1:0] EFF_RB       = 6'd13;
	localparam logic [EffW-1:0] EFF_RG       = 6'd14;
	localparam logic [EffW-1:0] EFF_DIV      = 6'd15;
	localparam logic [EffW-1:0] EFF_MUL      = 6'd16;
	localparam logic [EffW-1:0] EFF_SUB      = 6'd17;
	localparam logic [EffW-1:0] EFF_ADD      = 6'd18;
	localparam logic [EffW-1:0] EFF_MOD      = 6'd19;
	localparam logic [EffW-1:0] EFF_INV_MOD  = 6'd20;

	// modifier bit positions in the style register
	localparam int MOD_INVERT  = 6;
	localparam int MOD_KEY_TR  = 7;
	localparam int MOD_KEY_COL = 8;
	localparam int MOD_MAG1    = 10;
	localparam int MOD_MAG2    = 11;

endpackage

`default_nettype wire

>>> rtl/core/pae_divider.sv
// Pipelined restoring divider, two quotient bits per stage, no control state.
`default_nettype none

module pae_divider (
	input  wire logic                       clk,
	input  wire logic [pae_pkg::DivNW-1:0]  dividend,
	input  wire logic [pae_pkg::DivDW-1:0]  divisor,
	output logic      [pae_pkg::DivQW-1:0]  quotient
);
	import pae_pkg::*;

	localparam int Stages = DivQW / DivStep;

	logic [DivNW-1:0] rem_s [1:Stages];
	logic [DivDW-1:0] dvs_s [1:Stages];
	logic [DivQW-1:0] quo_s [1:Stages];

	for (genvar i = 0; i < Stages; i++) begin : g_stage
		logic [DivNW-1:0] rem_in;
		logic [DivDW-1:0] dvs_in;
		logic [DivQW-1:0] quo_in;
		logic [DivNW-1:0] rem_c;
		logic [DivQW-1:0] quo_c;
		logic [DivNW-1:0] sub_c;

		// pick the stage input: port for the first stage, previous register after
		if (i == 0) begin : g_first
			assign rem_in = dividend;
			assign dvs_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign dvs_in = dvs_s[i];
			assign quo_in = quo_s[i];
		end

		// resolve this stage's quotient bits, highest first
		always_comb begin
			rem_c = rem_in;
			quo_c = quo_in;
			sub_c = '0;
			for (int j = 0; j < DivStep; j++) begin
				sub_c = DivNW'(dvs_in) << (DivQW - 1 - DivStep * i - j);
				if (rem_c >= sub_c) begin
					rem_c = rem_c - sub_c;
					quo_c[DivQW - 1 - DivStep * i - j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= rem_c;
			dvs_s[i+1] <= dvs_in;
			quo_s[i+1] <= quo_c;
		end
	end

	assign quotient = quo_s[Stages];

endmodule

`default_nettype wire

>>> rtl/core/pixel_alpha_effect_core.sv
// Top level of the pixel alpha effect core: config registers and the pixel pipeline.
// A pixel taken with start passes stages 1 and 2, the divider and the output
// register; its result shows for one cycle, with done high. Throughput: one pixel
// per cycle, busy stays low; the depth is set by the four-stage shared divider for
// saturation and divide. Reset clears the valid bits and sets the registers to their
// reset values (style 0, alpha 255, key black); pixels in flight at reset are dropped.
`default_nettype none

module pixel_alpha_effect_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr,
	input  wire logic [pae_pkg::CfgAW-1:0]   cfg_addr,
	input  wire logic [pae_pkg::CfgDW-1:0]   cfg_data,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [pae_pkg::ColW-1:0]    red_in,
	input  wire logic [pae_pkg::ColW-1:0]    green_in,
	input  wire logic [pae_pkg::ColW-1:0]    blue_in,
	input  wire logic [pae_pkg::ColW-1:0]    alpha_in,
	input  wire logic                        last_in,
	output logic                             done,
	output logic      [pae_pkg::ColW-1:0]    red_out,
	output logic      [pae_pkg::ColW-1:0]    green_out,
	output logic      [pae_pkg::ColW-1:0]    blue_out,
	output logic      [pae_pkg::ColW-1:0]    alpha_out,
	output logic                             last_out
);
	import pae_pkg::*;

	localparam int SumW  = ColW + 2;
	localparam int PrdW  = SumW + Rcp3W;
	localparam int DivLat = DivQW / DivStep;
	localparam int FirstSide = 3;
	localparam int LastSide  = FirstSide + DivLat - 1;

	typedef struct packed {
		logic [ColW-1:0] r;
		logic [ColW-1:0] g;
		logic [ColW-1:0] b;
		logic            last;
		logic            key;
		logic            use_div;
		logic            zero_black;
		logic [ColW-1:0] base;
	} side_t;

	// configuration registers
	logic [StyleW-1:0] style_q;
	logic [ColW-1:0]   eff_alpha_q;
	logic [ColW-1:0]   key_r_q;
	logic [ColW-1:0]   key_g_q;
	logic [ColW-1:0]   key_b_q;
	logic [EffW-1:0]   code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q     <= '0;
			eff_alpha_q <= COL_MAX;
			key_r_q     <= '0;
			key_g_q     <= '0;
			key_b_q     <= '0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_STYLE: style_q     <= cfg_data;
				REG_ALPHA: eff_alpha_q <= cfg_data[ColW-1:0];
				REG_KEY_R: key_r_q     <= cfg_data[ColW-1:0];
				REG_KEY_G: key_g_q     <= cfg_data[ColW-1:0];
				REG_KEY_B: key_b_q     <= cfg_data[ColW-1:0];
				default: ;
			endcase
		end
	end

	assign code = style_q[EffW-1:0];
	assign busy = 1'b0;

	// valid bits for every stage up to the output
	logic [LastSide:1] vld_s;
	logic              take;

	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[LastSide-1:1], take};
			done  <= vld_s[LastSide];
		end
	end

	// stage 1: min, max, key match, channel sum and distance from mid-gray
	logic [ColW-1:0] mn_c, mx_c;
	logic [ColW-1:0] dr_c, dg_c, db_c;
	logic            key_c;

	always_comb begin
		mn_c = red_in;
		mx_c = red_in;
		if (green_in < mn_c) mn_c = green_in;
		if (blue_in < mn_c)  mn_c = blue_in;
		if (green_in > mx_c) mx_c = green_in;
		if (blue_in > mx_c)  mx_c = blue_in;
		dr_c = (red_in >= COL_HALF) ? red_in - COL_HALF : COL_HALF - red_in;
		dg_c = (green_in >= COL_HALF) ? green_in - COL_HALF : COL_HALF - green_in;
		db_c = (blue_in >= COL_HALF) ? blue_in - COL_HALF : COL_HALF - blue_in;
		key_c = (red_in == key_r_q) && (green_in == key_g_q) && (blue_in == key_b_q);
	end

	logic [ColW-1:0] r_s1, g_s1, b_s1, a_s1, mn_s1, mx_s1;
	logic            last_s1, key_s1;
	logic [SumW-1:0] sum_s1, dist_s1;

	always_ff @(posedge clk) begin
		r_s1    <= red_in;
		g_s1    <= green_in;
		b_s1    <= blue_in;
		a_s1    <= alpha_in;
		last_s1 <= last_in;
		key_s1  <= key_c;
		mn_s1   <= mn_c;
		mx_s1   <= mx_c;
		sum_s1  <= SumW'(red_in) + SumW'(green_in) + SumW'(blue_in);
		dist_s1 <= (SumW'(dr_c) + SumW'(dg_c) + SumW'(db_c)) << 1;
	end

	// stage 2: divide-by-three products, alpha product, divider operands
	logic [PrdW-1:0]   q3p_c, mp_c;
	logic [DivNW-1:0]  ap_c;
	logic [ColW-1:0]   spread_c;
	logic [DivNW-1:0]  dvd_c;
	logic [DivDW-1:0]  dvs_c;

	always_comb begin
		q3p_c    = PrdW'(sum_s1) * PrdW'(RCP3);
		mp_c     = PrdW'(dist_s1) * PrdW'(RCP3);
		ap_c     = DivNW'(a_s1) * DivNW'(eff_alpha_q);
		spread_c = mx_s1 - mn_s1;
		if (code == EFF_SAT) begin
			dvd_c = {spread_c, {ColW{1'b0}}} - DivNW'(spread_c);
			dvs_c = mx_s1;
		end else begin
			dvd_c = DivNW'(a_s1);
			dvs_c = eff_alpha_q;
		end
	end

	logic [ColW-1:0]  r_s2, g_s2, b_s2, a_s2, mn_s2, mx_s2;
	logic             last_s2, key_s2;
	logic [ColW-1:0]  q3_s2;
	logic [ColW:0]    m_s2;
	logic [DivNW-1:0] ap_s2;
	logic [DivNW-1:0] dvd_s2;
	logic [DivDW-1:0] dvs_s2;

	always_ff @(posedge clk) begin
		r_s2    <= r_s1;
		g_s2    <= g_s1;
		b_s2    <= b_s1;
		a_s2    <= a_s1;
		last_s2 <= last_s1;
		key_s2  <= key_s1;
		mn_s2   <= mn_s1;
		mx_s2   <= mx_s1;
		q3_s2   <= q3p_c[Rcp3Sh+ColW-1:Rcp3Sh];
		m_s2    <= mp_c[Rcp3Sh+ColW:Rcp3Sh];
		ap_s2   <= ap_c;
		dvd_s2  <= dvd_c;
		dvs_s2  <= dvs_c;
	end

	// stages 3 to 6: shared divider
	logic [DivQW-1:0] quo;

	pae_divider u_div (
		.clk      (clk),
		.dividend (dvd_s2),
		.divisor  (dvs_s2),
		.quotient (quo)
	);

	// stage 3 side path: pick the base alpha for every effect but the divides
	logic [ColW-1:0] m_sat_c;
	logic [ColW:0]   add_c;
	side_t           side_c;

	always_comb begin
		m_sat_c = (m_s2 > (ColW+1)'(COL_MAX)) ? COL_MAX : m_s2[ColW-1:0];
		add_c   = (ColW+1)'(a_s2) + (ColW+1)'(eff_alpha_q);
		side_c.r          = r_s2;
		side_c.g          = g_s2;
		side_c.b          = b_s2;
		side_c.last       = last_s2;
		side_c.key        = key_s2;
		side_c.use_div    = (code == EFF_SAT) || (code == EFF_DIV);
		side_c.zero_black = (code == EFF_SAT) && (mx_s2 == '0);
		case (code)
			EFF_SET:     side_c.base = eff_alpha_q;
			EFF_KEY_OPQ: side_c.base = key_s2 ? COL_MAX : eff_alpha_q;
			EFF_KEY_CLR: side_c.base = key_s2 ? eff_alpha_q : COL_MAX;
			EFF_BRIGHT:  side_c.base = q3_s2;
			EFF_LIGHT:   side_c.base = ColW'(((ColW+1)'(mn_s2) + (ColW+1)'(mx_s2)) >> 1);
			EFF_MIN:     side_c.base = mn_s2;
			EFF_MAX:     side_c.base = mx_s2;
			EFF_RED:     side_c.base = r_s2;
			EFF_GREEN:   side_c.base = g_s2;
			EFF_BLUE:    side_c.base = b_s2;
			EFF_GB:      side_c.base = ColW'(((ColW+1)'(g_s2) + (ColW+1)'(b_s2)) >> 1);
			EFF_RB:      side_c.base = ColW'(((ColW+1)'(r_s2) + (ColW+1)'(b_s2)) >> 1);
			EFF_RG:      side_c.base = ColW'(((ColW+1)'(r_s2) + (ColW+1)'(g_s2)) >> 1);
			EFF_MUL:     side_c.base = (ap_s2 > DivNW'(COL_MAX)) ? COL_MAX
							: ap_s2[ColW-1:0];
			EFF_SUB:     side_c.base = (a_s2 > eff_alpha_q) ? a_s2 - eff_alpha_q : '0;
			EFF_ADD:     side_c.base = add_c[ColW] ? COL_MAX : add_c[ColW-1:0];
			EFF_MOD:     side_c.base = m_sat_c;
			EFF_INV_MOD: side_c.base = COL_MAX - m_sat_c;
			default:     side_c.base = a_s2;
		endcase
	end

	// hold the side data alongside the divider stages
	side_t side_s [FirstSide:LastSide];

	always_ff @(posedge clk) begin
		side_s[FirstSide] <= side_c;
		for (int i = FirstSide + 1; i <= LastSide; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	// output stage: merge divider result, then apply modifiers in order
	side_t           fin;
	logic [ColW-1:0] alpha_c, r_c, g_c, b_c;

	always_comb begin
		fin = side_s[LastSide];
		if (fin.use_div) begin
			alpha_c = fin.zero_black ? '0 : quo;
		end else begin
			alpha_c = fin.base;
		end
		if (style_q[MOD_INVERT]) alpha_c = COL_MAX - alpha_c;
		if (style_q[MOD_KEY_TR] && fin.key) alpha_c = '0;
		r_c = fin.r;
		g_c = fin.g;
		b_c = fin.b;
		if (style_q[MOD_KEY_COL]) begin
			r_c = key_r_q;
			g_c = key_g_q;
			b_c = key_b_q;
		end
		if (style_q[MOD_MAG1] && r_c == COL_HALF && g_c == '0 && b_c == COL_HALF) begin
			r_c     = '0;
			b_c     = '0;
			alpha_c = ALPHA_HALF;
		end else if (style_q[MOD_MAG2] && r_c == COL_MAG2 && g_c == '0 && b_c == COL_MAG2) begin
			r_c     = '0;
			b_c     = '0;
			alpha_c = ALPHA_QUARTER;
		end
	end

	always_ff @(posedge clk) begin
		red_out   <= r_c;
		green_out <= g_c;
		blue_out  <= b_c;
		alpha_out <= alpha_c;
		last_out  <= fin.last;
	end

endmodule

`default_nettype wire
